[rtl/core/modular_exponentiation_defines.svh]
// Assertion macros for the checker file of the modular exponentiation block.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MEXP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("modexp check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MEXP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("modexp check failed");

`endif

[rtl/core/mexp_pkg.sv]
// Shared widths, types and register indexes of the modular exponentiation block.
// Depends on nothing.
package mexp_pkg;

  localparam int unsigned WIDTH  = 32;
  localparam int unsigned CNT_W  = $clog2(WIDTH);
  localparam int unsigned BITS_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  // Configuration register indexes
  localparam logic CFG_MODULUS  = 1'b0;
  localparam logic CFG_EXPONENT = 1'b1;

  // Request to the modular multiplier
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  // Response of the modular multiplier
  typedef struct packed {
    logic  done;
    word_t prod;
  } mul_rsp_t;

endpackage

[rtl/core/modular_exponentiation.sv]
// Modular exponentiation: power_result = base_value ^ exponent mod modulus, 32-bit unsigned.
// Depends on mexp_pkg and mexp_mulmod (bit-serial modular multiplier).
//
// One request at a time. The exponent is scanned left to right from its most
// significant set bit: every bit costs a modular square, a one bit also a modular
// multiply by the base. All products run through one bit-serial multiplier that
// consumes one multiplier bit per cycle. A request is accepted, the base is
// reduced mod modulus, the leading zeros of the exponent are skipped one per
// cycle, and then the squares and multiplies run in turn. Exponent zero returns
// 1, also for modulus zero; a nonzero exponent with modulus zero returns 0.
// The result sits in an output register, so the next request is taken while
// the previous result still waits downstream. Configuration writes (index 0
// modulus, index 1 exponent) take effect at once and must only be made while
// the block is idle.
module modular_exponentiation (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mexp_pkg::word_t        base_value_i,
  // Result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mexp_pkg::word_t        power_result_o,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  mexp_pkg::word_t        cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } state_e;

  // Configuration registers
  mexp_pkg::word_t modulus_q;
  mexp_pkg::word_t exponent_q;

  // Sequencer state and datapath registers
  state_e                       state_q;
  mexp_pkg::word_t              x_q;       // running power
  mexp_pkg::word_t              bred_q;    // base reduced mod modulus
  mexp_pkg::word_t              e_q;       // exponent, shifted left as bits are used
  logic [mexp_pkg::BITS_W-1:0]  bits_q;    // exponent bits still to process
  logic                         mstart_q;
  mexp_pkg::word_t              ma_q;
  mexp_pkg::word_t              mb_q;
  logic                         out_valid_q;
  mexp_pkg::word_t              result_q;

  mexp_pkg::mul_req_t mul_req;
  mexp_pkg::mul_rsp_t mul_rsp;
  mexp_pkg::word_t    one_mod;

  // 1 mod n: zero for modulus one
  assign one_mod = (modulus_q == mexp_pkg::WIDTH'(1)) ? '0 : mexp_pkg::WIDTH'(1);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= mexp_pkg::WIDTH'(1);
      exponent_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mexp_pkg::CFG_MODULUS:  modulus_q  <= cfg_wdata_i;
        mexp_pkg::CFG_EXPONENT: exponent_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign mul_req.start = mstart_q;
  assign mul_req.a     = ma_q;
  assign mul_req.b     = mb_q;

  mexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_i    (modulus_q),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Sequencer: holds state, datapath and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      bred_q      <= '0;
      e_q         <= '0;
      bits_q      <= '0;
      mstart_q    <= 1'b0;
      ma_q        <= '0;
      mb_q        <= '0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      // start is a one-cycle pulse
      mstart_q <= 1'b0;
      // drop the result once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            e_q    <= exponent_q;
            bits_q <= mexp_pkg::BITS_W'(mexp_pkg::WIDTH);
            if (exponent_q == '0) begin
              // exponent zero: result is 1 for every modulus
              x_q     <= mexp_pkg::WIDTH'(1);
              state_q <= ST_FINISH;
            end else if (modulus_q == '0) begin
              x_q     <= '0;
              state_q <= ST_FINISH;
            end else begin
              // reduce the base: 1 * base mod n
              mstart_q <= 1'b1;
              ma_q     <= mexp_pkg::WIDTH'(1);
              mb_q     <= base_value_i;
              state_q  <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mul_rsp.done) begin
            bred_q  <= mul_rsp.prod;
            x_q     <= one_mod;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // skip leading zeros; the exponent is known nonzero here
          if (e_q[mexp_pkg::WIDTH-1]) begin
            mstart_q <= 1'b1;
            ma_q     <= x_q;
            mb_q     <= x_q;
            state_q  <= ST_SQUARE;
          end else begin
            e_q    <= {e_q[mexp_pkg::WIDTH-2:0], 1'b0};
            bits_q <= bits_q - 1'b1;
          end
        end
        ST_SQUARE: begin
          if (mul_rsp.done) begin
            x_q <= mul_rsp.prod;
            if (e_q[mexp_pkg::WIDTH-1]) begin
              mstart_q <= 1'b1;
              ma_q     <= mul_rsp.prod;
              mb_q     <= bred_q;
              state_q  <= ST_MULT;
            end else if (bits_q == mexp_pkg::BITS_W'(1)) begin
              state_q <= ST_FINISH;
            end else begin
              // advance to the next exponent bit
              e_q      <= {e_q[mexp_pkg::WIDTH-2:0], 1'b0};
              bits_q   <= bits_q - 1'b1;
              mstart_q <= 1'b1;
              ma_q     <= mul_rsp.prod;
              mb_q     <= mul_rsp.prod;
            end
          end
        end
        ST_MULT: begin
          if (mul_rsp.done) begin
            x_q <= mul_rsp.prod;
            if (bits_q == mexp_pkg::BITS_W'(1)) begin
              state_q <= ST_FINISH;
            end else begin
              e_q      <= {e_q[mexp_pkg::WIDTH-2:0], 1'b0};
              bits_q   <= bits_q - 1'b1;
              mstart_q <= 1'b1;
              ma_q     <= mul_rsp.prod;
              mb_q     <= mul_rsp.prod;
              state_q  <= ST_SQUARE;
            end
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            result_q    <= x_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign power_result_o = result_q;

endmodule

[rtl/core/mexp_mulmod.sv]
// Bit-serial interleaved modular multiplier: (a * b) mod n, one bit of b per cycle.
// Depends on mexp_pkg. Operands must satisfy a <= n and the accumulator stays below n.
module mexp_mulmod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mexp_pkg::word_t     n_i,
  input  mexp_pkg::mul_req_t  req_i,
  output mexp_pkg::mul_rsp_t  rsp_o
);

  mexp_pkg::word_t                 acc_q;
  mexp_pkg::word_t                 a_q;
  mexp_pkg::word_t                 b_q;
  logic [mexp_pkg::CNT_W-1:0]      cnt_q;
  logic                            busy_q;
  logic                            done_q;

  logic [mexp_pkg::WIDTH:0]        n_ext;
  logic [mexp_pkg::WIDTH:0]        dbl;
  logic [mexp_pkg::WIDTH:0]        dbl_red;
  logic [mexp_pkg::WIDTH:0]        sum;
  logic [mexp_pkg::WIDTH:0]        sum_red;

  // Double the accumulator, reduce, then add a for a one bit and reduce again
  always_comb begin
    n_ext   = {1'b0, n_i};
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
    sum     = {1'b0, dbl_red[mexp_pkg::WIDTH-1:0]} +
              (b_q[mexp_pkg::WIDTH-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= n_ext) ? (sum - n_ext) : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= sum_red[mexp_pkg::WIDTH-1:0];
        b_q   <= {b_q[mexp_pkg::WIDTH-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

[rtl/core/mexp_checker.sv]
// Port-level checker for the modular exponentiation block, bound to the top level.
// Depends on modular_exponentiation_defines.svh, mexp_pkg and the top-level ports.
`include "modular_exponentiation_defines.svh"

module mexp_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input mexp_pkg::word_t power_result_o
);

  // One request at a time: ready drops after every accepted request
  `MEXP_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // Ready only drops because a request was taken
  `MEXP_ASSERT_IMP(a_ready_falls_on_accept, $fell(in_ready_o), $past(in_valid_i))

  // A new result appears only after the block was working on a request
  `MEXP_ASSERT_IMP(a_result_after_work, $rose(out_valid_o), !$past(in_ready_o))

  // A stalled result holds
  `MEXP_ASSERT_NXT(a_result_holds, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(power_result_o))

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);
